FILE: src/ple_pkg.sv
package ple_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CAPACITY_DEF = 16;

  typedef enum logic [2:0] {
    K_INS_FRONT = 3'd0,
    K_INS_END   = 3'd1,
    K_INS_POS   = 3'd2,
    K_DEL_FRONT = 3'd3,
    K_DEL_END   = 3'd4,
    K_DEL_POS   = 3'd5,
    K_DUMP      = 3'd6,
    K_NONE      = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

endpackage

FILE: src/ple_ram.sv
module ple_ram import ple_pkg::*; #(
  parameter int unsigned WIDTH = DATA_W,
  parameter int unsigned DEPTH = CAPACITY_DEF,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: src/positional_list_engine.sv
// Append and every full, empty or out-of-range word are answered from idle without a walk;
// other inserts shift the words from the index up one slot, then write the value; deletes
// shift the later words down one slot and return the deleted element; dump reads every element.
// The one-read, one-write element RAM moves one element per cycle; busy holds input off.
// The receiver cannot stall: each result word is strobed for exactly one cycle.
// Reset empties the list at once (count cleared); RAM contents are left as they are.
module positional_list_engine import ple_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               kind_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [5:0]               position_i,
  output logic                     result_valid_o,
  output logic [1:0]               status_o,
  output logic signed [DATA_W-1:0] element_o,
  output logic                     last_o
);

  localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > 6) ? CW : 6;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_UP    = 5'b00010,
    S_DN    = 5'b00100,
    S_DRAIN = 5'b01000,
    S_PUT   = 5'b10000
  } state_e;

  typedef enum logic [1:0] {
    OP_INS  = 2'd0,
    OP_DEL  = 2'd1,
    OP_DUMP = 2'd2
  } op_e;

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [AW-1:0]     lo_q, lo_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic              rd_vld_q, rd_vld_d;
  logic [AW-1:0]     rd_addr_q, rd_addr_d;

  logic              rv_q, rv_d;
  status_e           st_q, st_d;
  logic [DATA_W-1:0] el_q, el_d;
  logic              la_q, la_d;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [DATA_W-1:0] wdata, rdata;

  logic [CMPW-1:0]   pos_x, cnt_x;
  logic [AW-1:0]     last_idx;
  logic [AW-1:0]     ins_idx, del_idx;
  logic              full, empty;
  logic [DATA_W-1:0] del_val;

  assign pos_x    = CMPW'(position_i);
  assign cnt_x    = CMPW'(cnt_q);
  assign last_idx = AW'(cnt_q - CW'(1));
  assign full     = (cnt_q == CW'(CAPACITY));
  assign empty    = (cnt_q == '0);
  assign del_val  = (rd_addr_q == lo_q) ? rdata : val_q;

  always_comb begin
    ins_idx = '0;
    del_idx = '0;
    unique case (kind_e'(kind_i))
      K_INS_END: ins_idx = AW'(cnt_q);
      K_INS_POS: begin
        if (pos_x <= CMPW'(1) || empty) begin
          ins_idx = '0;
        end else if (pos_x - CMPW'(1) < cnt_x) begin
          ins_idx = AW'(pos_x - CMPW'(1));
        end else begin
          ins_idx = AW'(cnt_q);
        end
      end
      K_DEL_END: del_idx = last_idx;
      K_DEL_POS: begin
        if (pos_x > CMPW'(1)) begin
          del_idx = AW'(pos_x - CMPW'(1));
        end
      end
      default: begin
        ins_idx = '0;
        del_idx = '0;
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    lo_d      = lo_q;
    ptr_d     = ptr_q;
    cnt_d     = cnt_q;
    val_d     = val_q;
    rd_vld_d  = 1'b0;
    rd_addr_d = rd_addr_q;
    rv_d      = 1'b0;
    st_d      = st_q;
    el_d      = el_q;
    la_d      = la_q;
    we        = 1'b0;
    waddr     = '0;
    wdata     = val_q;
    raddr     = ptr_q;

    // data phase: word read last cycle is on rdata
    if (rd_vld_q) begin
      unique case (op_q)
        OP_INS: begin
          we    = 1'b1;
          waddr = rd_addr_q + AW'(1);
          wdata = rdata;
        end
        OP_DEL: begin
          if (rd_addr_q == lo_q) begin
            val_d = rdata;
          end else begin
            we    = 1'b1;
            waddr = rd_addr_q - AW'(1);
            wdata = rdata;
          end
        end
        OP_DUMP: begin
          rv_d = 1'b1;
          st_d = ST_OK;
          el_d = rdata;
          la_d = (rd_addr_q == last_idx);
        end
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (kind_e'(kind_i))
            K_INS_FRONT, K_INS_END, K_INS_POS: begin
              if (full) begin
                rv_d = 1'b1;
                st_d = ST_FULL;
                el_d = '0;
                la_d = 1'b1;
              end else if (ins_idx == AW'(cnt_q)) begin
                // append: nothing moves
                we    = 1'b1;
                waddr = ins_idx;
                wdata = value_i;
                cnt_d = cnt_q + CW'(1);
                rv_d  = 1'b1;
                st_d  = ST_OK;
                el_d  = '0;
                la_d  = 1'b1;
              end else begin
                op_d    = OP_INS;
                lo_d    = ins_idx;
                ptr_d   = last_idx;
                val_d   = value_i;
                state_d = S_UP;
              end
            end
            K_DEL_FRONT, K_DEL_END, K_DEL_POS: begin
              if (empty) begin
                rv_d = 1'b1;
                st_d = ST_EMPTY;
                el_d = '0;
                la_d = 1'b1;
              end else if (kind_e'(kind_i) == K_DEL_POS && pos_x > cnt_x) begin
                rv_d = 1'b1;
                st_d = ST_RANGE;
                el_d = '0;
                la_d = 1'b1;
              end else begin
                op_d    = OP_DEL;
                lo_d    = del_idx;
                ptr_d   = del_idx;
                state_d = S_DN;
              end
            end
            K_DUMP: begin
              if (empty) begin
                rv_d = 1'b1;
                st_d = ST_EMPTY;
                el_d = '0;
                la_d = 1'b1;
              end else begin
                op_d    = OP_DUMP;
                lo_d    = '0;
                ptr_d   = '0;
                state_d = S_DN;
              end
            end
            default: ;
          endcase
        end
      end
      S_UP: begin
        // walk down from the tail, each word moves one slot up
        raddr     = ptr_q;
        rd_vld_d  = 1'b1;
        rd_addr_d = ptr_q;
        if (ptr_q == lo_q) begin
          state_d = S_DRAIN;
        end else begin
          ptr_d = ptr_q - AW'(1);
        end
      end
      S_DN: begin
        raddr     = ptr_q;
        rd_vld_d  = 1'b1;
        rd_addr_d = ptr_q;
        if (ptr_q == last_idx) begin
          state_d = S_DRAIN;
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end
      S_DRAIN: begin
        unique case (op_q)
          OP_INS:  state_d = S_PUT;
          OP_DEL: begin
            rv_d    = 1'b1;
            st_d    = ST_OK;
            el_d    = del_val;
            la_d    = 1'b1;
            cnt_d   = cnt_q - CW'(1);
            state_d = S_IDLE;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_PUT: begin
        we      = 1'b1;
        waddr   = lo_q;
        wdata   = val_q;
        cnt_d   = cnt_q + CW'(1);
        rv_d    = 1'b1;
        st_d    = ST_OK;
        el_d    = '0;
        la_d    = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= OP_INS;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      rv_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= rd_vld_d;
      rv_q     <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q      <= lo_d;
    ptr_q     <= ptr_d;
    val_q     <= val_d;
    rd_addr_q <= rd_addr_d;
    st_q      <= st_d;
    el_q      <= el_d;
    la_q      <= la_d;
  end

  ple_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = rv_q;
  assign status_o       = st_q;
  assign element_o      = el_q;
  assign last_o         = la_q;

  a_idle_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !rd_vld_q)
    else $error("read pending while idle");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != ST_OK) |-> last_o)
    else $error("error word without last flag");

  a_walk_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DN) |-> (CW'(ptr_q) < cnt_q))
    else $error("walk pointer past end of list");

  a_put_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUT) |-> $past(state_q == S_DRAIN))
    else $error("insert write without finished shift");

endmodule
